@@ design/tsfe_pkg.sv @@
package tsfe_pkg;

	localparam int unsigned FRAME_LEN = 10;
	localparam int unsigned CNT_W     = $clog2(FRAME_LEN);

	localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(FRAME_LEN - 1);

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] CHECK_BASE = 8'd64;
	localparam logic [7:0] BYTE_CR    = 8'd13;
	localparam logic [7:0] BYTE_LF    = 8'd10;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [6:0] quo;
		logic [3:0] rem;
	} div10_t;

	// Divide a 10-bit value by ten: multiply by 205/2048, exact below 1029.
	function automatic div10_t div10(input logic [9:0] x);
		logic [17:0] prod;
		logic [13:0] back;
		div10_t      res;
		prod    = {8'd0, x} * 18'd205;
		res.quo = prod[17:11];
		back    = {7'd0, res.quo} * 14'd10;
		res.rem = 4'(x - back[9:0]);
		return res;
	endfunction

	function automatic byte_t ascii_digit(input logic [3:0] d);
		return ASCII_ZERO + {4'd0, d};
	endfunction

endpackage

@@ design/timer_serial_frame_encoder.sv @@
// Timer serial frame encoder. Each input word carries a status byte and a
// time (minutes, seconds, milliseconds) and turns into a ten-byte frame on
// the output channel: status, minute ones, second tens and ones, millisecond
// hundreds, tens and ones as ASCII digits, a checksum of 64 plus the digit
// sum, then CR and LF, with last_byte high on the LF. One frame byte leaves
// per cycle while byte_stall is low; that output byte slot is what sets the
// sustained item rate. An accepted word goes through the input register and
// then the frame register, which drives the output byte. The input register
// takes the next word while the current frame is still being sent, and the
// frame register reloads in the same cycle the LF byte is taken, so frames
// follow each other with no gap. A millisecond value above 999 sends a
// hundreds digit of ten, which appears as ':' and counts as ten in the
// checksum.
module timer_serial_frame_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] status_char,
	input  logic [6:0] minutes,
	input  logic [5:0] seconds,
	input  logic [9:0] milliseconds,
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [7:0] frame_byte,
	output logic       last_byte
);

	// Input register
	logic       valid_s1;
	logic [7:0] status_s1;
	logic [6:0] minutes_s1;
	logic [5:0] seconds_s1;
	logic [9:0] msec_s1;

	// Frame register and byte counter
	logic                         valid_s2;
	tsfe_pkg::byte_t              frame_s2 [tsfe_pkg::FRAME_LEN];
	logic [tsfe_pkg::CNT_W-1:0]   slot_q;

	logic byte_take;
	logic frame_done;
	logic load_s2;

	tsfe_pkg::div10_t min_dv;
	tsfe_pkg::div10_t sec_dv;
	tsfe_pkg::div10_t ms_dv;
	tsfe_pkg::div10_t ms_tens_dv;

	logic [3:0] dig_min;
	logic [3:0] dig_sec_t;
	logic [3:0] dig_sec_o;
	logic [3:0] dig_ms_h;
	logic [3:0] dig_ms_t;
	logic [3:0] dig_ms_o;
	logic [5:0] dig_sum;

	tsfe_pkg::byte_t frame_next [tsfe_pkg::FRAME_LEN];

	assign byte_take  = valid_s2 && !byte_stall;
	assign frame_done = byte_take && (slot_q == tsfe_pkg::LAST_SLOT);
	// Reload the frame when it is empty or its last byte leaves this cycle.
	assign load_s2    = valid_s1 && (!valid_s2 || frame_done);
	// Hold the input word only while it cannot move into the frame register.
	assign item_stall = valid_s1 && !load_s2;

	// Split the time into decimal digits.
	always_comb begin
		min_dv     = tsfe_pkg::div10({3'd0, minutes_s1});
		sec_dv     = tsfe_pkg::div10({4'd0, seconds_s1});
		ms_dv      = tsfe_pkg::div10(msec_s1);
		ms_tens_dv = tsfe_pkg::div10({3'd0, ms_dv.quo});

		dig_min   = min_dv.rem;
		dig_sec_t = sec_dv.quo[3:0];
		dig_sec_o = sec_dv.rem;
		dig_ms_h  = ms_tens_dv.quo[3:0];
		dig_ms_t  = ms_tens_dv.rem;
		dig_ms_o  = ms_dv.rem;

		dig_sum = {2'd0, dig_min} + {2'd0, dig_sec_t} + {2'd0, dig_sec_o}
		        + {2'd0, dig_ms_h} + {2'd0, dig_ms_t} + {2'd0, dig_ms_o};

		frame_next[0] = status_s1;
		frame_next[1] = tsfe_pkg::ascii_digit(dig_min);
		frame_next[2] = tsfe_pkg::ascii_digit(dig_sec_t);
		frame_next[3] = tsfe_pkg::ascii_digit(dig_sec_o);
		frame_next[4] = tsfe_pkg::ascii_digit(dig_ms_h);
		frame_next[5] = tsfe_pkg::ascii_digit(dig_ms_t);
		frame_next[6] = tsfe_pkg::ascii_digit(dig_ms_o);
		frame_next[7] = tsfe_pkg::CHECK_BASE + {2'd0, dig_sum};
		frame_next[8] = tsfe_pkg::BYTE_CR;
		frame_next[9] = tsfe_pkg::BYTE_LF;
	end

	// Input stage: take a new word whenever the stage is not held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			status_s1  <= status_char;
			minutes_s1 <= minutes;
			seconds_s1 <= seconds;
			msec_s1    <= milliseconds;
		end
	end

	// Frame stage control: advance the slot on each taken byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			slot_q   <= '0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
			slot_q   <= '0;
		end else if (frame_done) begin
			valid_s2 <= 1'b0;
			slot_q   <= '0;
		end else if (byte_take) begin
			slot_q <= slot_q + 1'b1;
		end
	end

	// Frame bytes: load all ten, then shift toward slot zero as bytes leave.
	always_ff @(posedge clk) begin
		if (load_s2) begin
			frame_s2 <= frame_next;
		end else if (byte_take) begin
			for (int i = 0; i < tsfe_pkg::FRAME_LEN - 1; i++) begin
				frame_s2[i] <= frame_s2[i + 1];
			end
		end
	end

	assign byte_valid = valid_s2;
	assign frame_byte = frame_s2[0];
	assign last_byte  = (slot_q == tsfe_pkg::LAST_SLOT);

endmodule

@@ test/tb_timer_serial_frame_encoder.sv @@
module tb_timer_serial_frame_encoder;

	// One input word: status byte plus the time to encode.
	typedef struct packed {
		logic [7:0] status;
		logic [6:0] mins;
		logic [5:0] secs;
		logic [9:0] msec;
	} time_word_t;

	// One frame byte as it should leave the block.
	typedef struct {
		tsfe_pkg::byte_t value;
		logic            last;
	} frame_slot_t;

	localparam int unsigned RANDOM_WORDS = 300;
	localparam int unsigned TAIL_WORDS   = 30;   // no idling once this few remain
	localparam int unsigned HOLD_AT      = 40;   // words taken before the long hold-off
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 30;
	localparam int unsigned QUIET_LIMIT  = 3000; // cycles with no word moving on either side
	localparam int unsigned SHOW_MAX     = 10;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	logic       item_stall;
	logic [7:0] status_char  = '0;
	logic [6:0] minutes      = '0;
	logic [5:0] seconds      = '0;
	logic [9:0] milliseconds = '0;
	logic       byte_valid;
	logic       byte_stall   = 1'b0;
	logic [7:0] frame_byte;
	logic       last_byte;

	time_word_t  words_to_send[$];
	frame_slot_t frame_bytes_due[$];

	int unsigned words_taken = 0;
	int unsigned bytes_seen  = 0;
	int unsigned failures    = 0;
	int unsigned quiet       = 0;

	// Sender and receiver pacing: a gap is an idle burst, a run is a burst with no idling.
	int unsigned send_gap  = 0;
	int unsigned send_run  = 0;
	int unsigned recv_gap  = 0;
	int unsigned recv_run  = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	timer_serial_frame_encoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.status_char  (status_char),
		.minutes      (minutes),
		.seconds      (seconds),
		.milliseconds (milliseconds),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.frame_byte   (frame_byte),
		.last_byte    (last_byte)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Split the time into decimal digits and queue the ten bytes of its frame.
	// The millisecond hundreds digit is allowed to reach ten (':' on the wire).
	task automatic predict_frame(input time_word_t w);
		int unsigned digit[6];
		int unsigned digit_sum;
		frame_slot_t slot;
		digit[0]  = w.mins % 10;
		digit[1]  = w.secs / 10;
		digit[2]  = w.secs % 10;
		digit[3]  = w.msec / 100;
		digit[4]  = (w.msec / 10) % 10;
		digit[5]  = w.msec % 10;
		digit_sum = 0;
		slot.last = 1'b0;
		slot.value = w.status;
		frame_bytes_due.push_back(slot);
		for (int i = 0; i < 6; i++) begin
			digit_sum += digit[i];
			slot.value = tsfe_pkg::byte_t'(tsfe_pkg::ASCII_ZERO + tsfe_pkg::byte_t'(digit[i]));
			frame_bytes_due.push_back(slot);
		end
		slot.value = tsfe_pkg::byte_t'(tsfe_pkg::CHECK_BASE + tsfe_pkg::byte_t'(digit_sum));
		frame_bytes_due.push_back(slot);
		slot.value = tsfe_pkg::BYTE_CR;
		frame_bytes_due.push_back(slot);
		slot.value = tsfe_pkg::BYTE_LF;
		slot.last  = 1'b1;
		frame_bytes_due.push_back(slot);
	endtask

	task automatic queue_word(input logic [7:0] st, input logic [6:0] mn,
		input logic [5:0] sc, input logic [9:0] ms);
		time_word_t w;
		w.status = st;
		w.mins   = mn;
		w.secs   = sc;
		w.msec   = ms;
		words_to_send.push_back(w);
	endtask

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= SHOW_MAX)
			$display("byte %0d: %s", bytes_seen, msg);
	endtask

	// Sender: hold a stalled word, otherwise either idle a burst or offer the next word.
	// Predict a word's frame at the edge that accepts it, from the values on the pins.
	always @(posedge clk) begin
		time_word_t nxt;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				nxt.status = status_char;
				nxt.mins   = minutes;
				nxt.secs   = seconds;
				nxt.msec   = milliseconds;
				predict_frame(nxt);
				words_taken <= words_taken + 1;
			end
			if (!(item_valid && item_stall)) begin
				if (words_to_send.size() == 0) begin
					item_valid <= 1'b0;
				end else if (send_gap != 0 && words_to_send.size() > TAIL_WORDS
					&& hold_left == 0) begin
					item_valid <= 1'b0;
					send_gap   <= send_gap - 1;
				end else if (send_run == 0 && words_to_send.size() > TAIL_WORDS
					&& hold_left == 0 && $urandom_range(0, 1) == 1) begin
					// start an idle burst; this cycle counts as its first
					item_valid <= 1'b0;
					send_gap   <= $urandom_range(1, 15) - 1;
				end else begin
					nxt          = words_to_send.pop_front();
					item_valid   <= 1'b1;
					status_char  <= nxt.status;
					minutes      <= nxt.mins;
					seconds      <= nxt.secs;
					milliseconds <= nxt.msec;
					send_gap     <= 0;
					send_run     <= (send_run == 0) ? $urandom_range(1, 40) : send_run - 1;
				end
			end
		end
	end

	// Receiver: one long hold-off early on so the block backs up into its input,
	// then random stall bursts, and no stalls in the tail of the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				byte_stall <= 1'b1;
				hold_left  <= hold_left - 1;
			end else if (!hold_done && words_taken >= HOLD_AT) begin
				byte_stall <= 1'b1;
				hold_left  <= HOLD_CYCLES - 1;
				hold_done  <= 1'b1;
			end else if (words_to_send.size() <= TAIL_WORDS) begin
				byte_stall <= 1'b0;
			end else if (recv_gap != 0) begin
				byte_stall <= 1'b1;
				recv_gap   <= recv_gap - 1;
			end else if (recv_run == 0 && $urandom_range(0, 1) == 1) begin
				byte_stall <= 1'b1;
				recv_gap   <= $urandom_range(1, 15) - 1;
			end else begin
				byte_stall <= 1'b0;
				recv_run   <= (recv_run == 0) ? $urandom_range(1, 40) : recv_run - 1;
			end
		end
	end

	// Monitor: compare each taken byte, field by field, with the oldest one due.
	always @(posedge clk) begin
		frame_slot_t due;
		if (arst_n && byte_valid && !byte_stall) begin
			if (frame_bytes_due.size() == 0) begin
				note_failure($sformatf("unexpected byte 0x%02h (last %0b), nothing due",
					frame_byte, last_byte));
			end else begin
				due = frame_bytes_due.pop_front();
				if (frame_byte !== due.value)
					note_failure($sformatf("frame_byte expected 0x%02h, got 0x%02h",
						due.value, frame_byte));
				if (last_byte !== due.last)
					note_failure($sformatf("last_byte expected %0b, got %0b",
						due.last, last_byte));
			end
			bytes_seen++;
		end
	end

	// Count cycles in which no word moves on either channel.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (byte_valid && !byte_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
	end

	initial begin
		while (quiet < QUIET_LIMIT)
			@(posedge clk);
		$display("FAIL timer_serial_frame_encoder");
		$finish;
	end

	initial begin
		logic [7:0] st;
		// Directed words: field extremes, the idle status, and the out-of-range times
		// (minutes past 99, seconds 60 to 63, milliseconds 1000 to 1023).
		queue_word("I", 7'd0, 6'd0, 10'd0);
		queue_word(8'h00, 7'd0, 6'd0, 10'd0);
		queue_word(8'hFF, 7'd99, 6'd59, 10'd999);
		queue_word("S", 7'd9, 6'd59, 10'd999);
		queue_word(8'hFF, 7'd127, 6'd63, 10'd1023);
		queue_word("A", 7'd100, 6'd60, 10'd1000);
		queue_word(" ", 7'd10, 6'd61, 10'd1009);
		queue_word("L", 7'd119, 6'd62, 10'd1019);
		queue_word("R", 7'd1, 6'd10, 10'd100);
		queue_word("C", 7'd42, 6'd9, 10'd99);
		queue_word(8'h55, 7'd85, 6'd42, 10'd682);
		queue_word(8'hAA, 7'd42, 6'd21, 10'd341);
		queue_word(8'h80, 7'd64, 6'd32, 10'd512);
		queue_word(8'h01, 7'd63, 6'd31, 10'd511);
		queue_word("I", 7'd0, 6'd1, 10'd1);
		queue_word("S", 7'd5, 6'd50, 10'd990);
		queue_word("I", 7'd127, 6'd0, 10'd10);
		queue_word(8'h7F, 7'd0, 6'd63, 10'd0);
		queue_word(8'h30, 7'd99, 6'd0, 10'd1023);

		// Random words: mostly well-formed times with a plausible status, the rest
		// anything the field widths allow.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if ($urandom_range(0, 99) < 85) begin
				case ($urandom_range(0, 7))
					0: st = "I";
					1: st = "S";
					2: st = "L";
					3: st = "R";
					4: st = "C";
					5: st = "A";
					6: st = " ";
					default: st = 8'($urandom);
				endcase
				queue_word(st, 7'($urandom_range(0, 99)), 6'($urandom_range(0, 59)),
					10'($urandom_range(0, 999)));
			end else begin
				queue_word(8'($urandom), 7'($urandom), 6'($urandom), 10'($urandom));
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every word is accepted and every frame byte has come back.
		while (words_to_send.size() != 0 || item_valid)
			@(posedge clk);
		while (frame_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && frame_bytes_due.size() == 0)
			$display("PASS timer_serial_frame_encoder");
		else
			$display("FAIL timer_serial_frame_encoder");
		$finish;
	end

endmodule

@@ timer_serial_frame_encoder.f @@
design/tsfe_pkg.sv
design/timer_serial_frame_encoder.sv
test/tb_timer_serial_frame_encoder.sv
